FILE: hdl/stc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

    localparam int ID_W    = 64;
    localparam int CNT_W   = 16;
    localparam int TOTAL_W = 32;

    typedef logic [1:0]         t_opcode;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [TOTAL_W-1:0] t_total;

    localparam t_opcode OP_INC       = 2'd0;
    localparam t_opcode OP_FLUSH_ONE = 2'd1;
    localparam t_opcode OP_FLUSH_ALL = 2'd2;
    localparam t_opcode OP_READ      = 2'd3;

    localparam t_count DEFAULT_THRESHOLD = 16'd128;

    // register index taken from paddr[2]
    localparam logic REG_FLUSH_THRESHOLD = 1'b0;

endpackage

`default_nettype wire

FILE: hdl/stc_hash.sv
`timescale 1ns / 1ps
`default_nettype none

// id mod SLOTS: byte residues folded into a short sum, then a reciprocal
// multiply and one multiply-subtract, each step registered
module stc_hash #(
    parameter int SLOTS = 101,
    parameter int SW    = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [stc_pkg::ID_W-1:0] i_id,
    output logic                       o_done,
    output logic [SW-1:0]              o_slot
);
    import stc_pkg::*;

    localparam int CHUNK_W = 8;
    localparam int CHUNKS  = ID_W / CHUNK_W;
    // folded sum stays below CHUNKS * 2^CHUNK_W * 2^SW
    localparam int XW      = CHUNK_W + $clog2(CHUNKS) + SW;
    localparam int SHIFT   = XW + SW;
    localparam int MW      = XW + 2;
    localparam int QW      = MW - SW;
    localparam int PW      = XW + MW;

    typedef logic [CHUNKS-1:0][SW-1:0] t_weights;

    function automatic t_weights chunk_weights();
        t_weights    w;
        int unsigned r;
        r = 1 % SLOTS;
        for (int k = 0; k < CHUNKS; k++) begin
            w[k] = SW'(r);
            r    = (r << CHUNK_W) % SLOTS;
        end
        return w;
    endfunction

    // 2^(8k) mod SLOTS for byte k of the id
    localparam t_weights WEIGHTS = chunk_weights();
    // ceil(2^SHIFT / SLOTS): exact quotient for any sum below 2^XW
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

    logic                      r_vx;
    logic                      r_vq;
    logic                      r_done;
    logic [XW-1:0]             r_x;
    logic [XW-1:0]             r_x_d;
    logic [QW-1:0]             r_q;
    logic [SW-1:0]             r_rem;
    logic [XW-1:0]             n_x;
    logic [QW-1:0]             n_q;
    logic [CHUNKS-1:0][XW-1:0] part;
    logic [PW-1:0]             prod;
    logic [XW-1:0]             diff;

    always_comb begin
        for (int k = 0; k < CHUNKS; k++) begin
            part[k] = XW'(i_id[k*CHUNK_W +: CHUNK_W]) * XW'(WEIGHTS[k]);
        end
        n_x = ((part[0] + part[1]) + (part[2] + part[3]))
            + ((part[4] + part[5]) + (part[6] + part[7]));
    end

    assign prod = PW'(r_x) * PW'(RECIP);
    assign n_q  = QW'(prod >> SHIFT);
    assign diff = r_x_d - XW'(r_q) * XW'(SLOTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx   <= 1'b0;
            r_vq   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vx   <= i_start;
            r_vq   <= r_vx;
            r_done <= r_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= n_x;
        end
        if (r_vx) begin
            r_q   <= n_q;
            r_x_d <= r_x;
        end
        if (r_vq) begin
            r_rem <= diff[SW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem;

endmodule

`default_nettype wire

FILE: hdl/stc_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module stc_mem #(
    parameter int SLOTS = 101,
    parameter int SW    = 7
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [SW-1:0]          i_waddr,
    input  wire stc_pkg::t_count        i_wdata,
    input  wire logic                   i_re,
    input  wire logic [SW-1:0]          i_raddr,
    output stc_pkg::t_count             o_rdata
);
    import stc_pkg::*;

    t_count r_mem [SLOTS];
    t_count r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/sharded_threshold_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// Increment / flush-one: the id mod SLOTS unit, one slot read and one write-back lie
// between accepted beat and result. Flush-all / read: one slot per cycle through the
// single memory read port. One item at a time; the next beat is taken once the
// result is registered. After reset a clearing pass zeroes the slot memory while
// input is stalled; config writes are taken anytime.
module sharded_threshold_counter #(
    parameter int SLOTS = 101
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire stc_pkg::t_opcode          i_opcode,
    input  wire logic [stc_pkg::ID_W-1:0]  i_thread_id,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [stc_pkg::TOTAL_W-1:0]    o_count_value,
    output logic                           o_moved,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import stc_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_RMW    = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]    r_state;
    t_opcode       r_op;
    t_count        r_thr;
    t_total        r_global;
    t_total        r_acc;
    logic          r_moved;
    logic [WW-1:0] r_walk;
    logic          r_pv;
    logic [SW-1:0] r_paddr;
    logic [SW-1:0] r_slot;
    logic          r_o_valid;
    t_total        r_o_count;
    logic          r_o_moved;

    logic          accept;
    logic          hash_done;
    logic [SW-1:0] hash_slot;
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    t_count        mem_wdata;
    logic          mem_re;
    logic [SW-1:0] mem_raddr;
    t_count        mem_rdata;
    t_count        thr_eff;
    t_count        inc_val;
    logic          walk_more;
    logic          out_free;
    logic          cfg_wr;

    assign accept    = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign thr_eff   = (r_thr == '0) ? DEFAULT_THRESHOLD : r_thr;
    assign inc_val   = mem_rdata + 1'b1;
    assign walk_more = (r_walk < WW'(SLOTS));
    assign out_free  = !r_o_valid || !i_stall;

    stc_hash #(.SLOTS(SLOTS), .SW(SW)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && (i_opcode == OP_INC || i_opcode == OP_FLUSH_ONE)),
        .i_id    (i_thread_id),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    stc_mem #(.SLOTS(SLOTS), .SW(SW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_walk[SW-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_walk[SW-1:0];
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_HASH: begin
                mem_re    = hash_done;
                mem_raddr = hash_slot;
            end
            S_RMW: begin
                mem_we    = 1'b1;
                mem_waddr = r_slot;
                if (r_op == OP_INC && inc_val < thr_eff) begin
                    mem_wdata = inc_val;
                end
            end
            S_WALK: begin
                mem_re    = walk_more;
                mem_we    = r_pv && (r_op == OP_FLUSH_ALL);
                mem_waddr = r_paddr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_walk   <= '0;
            r_pv     <= 1'b0;
            r_global <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (r_walk == WW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_walk <= r_walk + 1'b1;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_opcode;
                        r_moved <= 1'b0;
                        r_acc   <= r_global;
                        r_walk  <= '0;
                        r_pv    <= 1'b0;
                        if (i_opcode == OP_INC || i_opcode == OP_FLUSH_ONE) begin
                            r_state <= S_HASH;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_slot  <= hash_slot;
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    if (r_op == OP_INC) begin
                        if (inc_val >= thr_eff) begin
                            r_global <= r_global + TOTAL_W'(inc_val);
                            r_moved  <= 1'b1;
                        end
                    end else if (mem_rdata != '0) begin
                        r_global <= r_global + TOTAL_W'(mem_rdata);
                        r_moved  <= 1'b1;
                    end
                    r_state <= S_FINISH;
                end
                S_WALK: begin
                    // read slot r_walk while the slot read last cycle is folded in
                    r_pv    <= walk_more;
                    r_paddr <= r_walk[SW-1:0];
                    if (walk_more) begin
                        r_walk <= r_walk + 1'b1;
                    end
                    if (r_pv) begin
                        if (r_op == OP_READ) begin
                            r_acc <= r_acc + TOTAL_W'(mem_rdata);
                        end else if (mem_rdata != '0) begin
                            r_global <= r_global + TOTAL_W'(mem_rdata);
                            r_moved  <= 1'b1;
                        end
                    end
                    if (!walk_more && !r_pv) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_FINISH && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && out_free) begin
            r_o_count <= (r_op == OP_READ) ? r_acc : r_global;
            r_o_moved <= r_moved;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_count_value = r_o_count;
    assign o_moved       = r_o_moved;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= DEFAULT_THRESHOLD;
        end else if (cfg_wr && paddr[2] == REG_FLUSH_THRESHOLD) begin
            r_thr <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FLUSH_THRESHOLD) ? {16'd0, r_thr} : 32'd0;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_HASH || r_state == S_WALK))
        else $error("accepted beat did not start work");

    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (r_state == S_HASH))
        else $error("hash result arrived outside hash wait");

    a_walk_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_pv) |-> (SW'(r_paddr) < SW'(SLOTS - 1) ||
                                         SW'(r_paddr) == SW'(SLOTS - 1)))
        else $error("walk address beyond slot count");

    a_read_moves_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_op == OP_READ) |-> !r_moved)
        else $error("read reported a move");

endmodule

`default_nettype wire
